>>> rtl/rpb_pkg.sv
package rpb_pkg;

    // Operation codes carried in the opcode field of an input beat.
    localparam logic [2:0] OP_SCALE = 3'd0;
    localparam logic [2:0] OP_MUL   = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_INV   = 3'd3;
    localparam logic [2:0] OP_BLEND = 3'd4;

    // One input beat: operation, two RGB565 pixels and an 8-bit factor.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] color_a;
        logic [15:0] color_b;
        logic [7:0]  factor;
    } pix_in_t;

    // One result beat: RGB565 pixel and its channels expanded to 8 bits.
    typedef struct packed {
        logic [15:0] result_color;
        logic [7:0]  result_red;
        logic [7:0]  result_green;
        logic [7:0]  result_blue;
    } pix_out_t;

endpackage

>>> rtl/rpb_alu.sv
module rpb_alu (
    input  rpb_pkg::pix_in_t  op_in,
    output rpb_pkg::pix_out_t op_out
);
    import rpb_pkg::*;

    localparam logic [7:0] FULL = 8'hFF;

    // Channel expansion: the 565 field sits at the top of a byte.
    function automatic logic [7:0] red8(input logic [15:0] p);
        red8 = {p[15:11], 3'b000};
    endfunction

    function automatic logic [7:0] green8(input logic [15:0] p);
        green8 = {p[10:5], 2'b00};
    endfunction

    function automatic logic [7:0] blue8(input logic [15:0] p);
        blue8 = {p[4:0], 3'b000};
    endfunction

    // Repack three bytes into RGB565 by dropping the low bits.
    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    // High byte of an 8 by 8 product.
    function automatic logic [7:0] mulhi(input logic [7:0] x, input logic [7:0] y);
        logic [15:0] prod;
        prod  = 16'(x) * 16'(y);
        mulhi = prod[15:8];
    endfunction

    // Scale every channel by f; a full factor passes the pixel through.
    function automatic logic [15:0] scale565(input logic [15:0] p, input logic [7:0] f);
        if (f == FULL) begin
            scale565 = p;
        end else if (f == 8'd0) begin
            scale565 = 16'd0;
        end else begin
            scale565 = pack565(mulhi(red8(p), f), mulhi(green8(p), f),
                               mulhi(blue8(p), f));
        end
    endfunction

    // Sum of two bytes, clamped at full scale.
    function automatic logic [7:0] sat8(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] sum;
        sum  = {1'b0, x} + {1'b0, y};
        sat8 = sum[8] ? FULL : sum[7:0];
    endfunction

    function automatic logic [15:0] add565(input logic [15:0] p, input logic [15:0] q);
        add565 = pack565(sat8(red8(p), red8(q)), sat8(green8(p), green8(q)),
                         sat8(blue8(p), blue8(q)));
    endfunction

    logic [15:0] scaled;
    logic [15:0] product;
    logic [15:0] summed;
    logic [15:0] inverted;
    logic [15:0] blended;
    logic [15:0] res;

    // All five operations are formed side by side.
    always_comb
    begin
        scaled   = scale565(op_in.color_a, op_in.factor);
        product  = pack565(mulhi(red8(op_in.color_a), red8(op_in.color_b)),
                           mulhi(green8(op_in.color_a), green8(op_in.color_b)),
                           mulhi(blue8(op_in.color_a), blue8(op_in.color_b)));
        summed   = add565(op_in.color_a, op_in.color_b);
        inverted = pack565(FULL - red8(op_in.color_a), FULL - green8(op_in.color_a),
                           FULL - blue8(op_in.color_a));
        // Equal pixels blend to the second pixel unchanged.
        if (op_in.color_a == op_in.color_b) begin
            blended = op_in.color_b;
        end else begin
            blended = add565(scale565(op_in.color_a, op_in.factor),
                             scale565(op_in.color_b, FULL - op_in.factor));
        end
    end

    // Select by opcode; unused codes give a black pixel.
    always_comb
    begin
        unique case (op_in.opcode)
            OP_SCALE: res = scaled;
            OP_MUL:   res = product;
            OP_ADD:   res = summed;
            OP_INV:   res = inverted;
            OP_BLEND: res = blended;
            default:  res = 16'd0;
        endcase
    end

    assign op_out.result_color = res;
    assign op_out.result_red   = red8(res);
    assign op_out.result_green = green8(res);
    assign op_out.result_blue  = blue8(res);

endmodule

>>> rtl/rgb565_pixel_blend_unit.sv
// Channel | Beat signals                      | Payload type
// --------+-----------------------------------+-------------------
// pixel   | pixel_valid, pixel_stall, pixel   | rpb_pkg::pix_in_t
// blend   | blend_valid, blend_stall, blend   | rpb_pkg::pix_out_t
//
// Every beat passes through an input register, then through the operation
// logic into the result register.
// A new beat is accepted every cycle while the result side keeps up.
// Two beats can be held while blend_stall is high; pixel_stall rises only
// when both registers are full and the result is not taken.
// rst_n clears both valid flags asynchronously; payload registers keep
// whatever they hold.
module rgb565_pixel_blend_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  rpb_pkg::pix_in_t  pixel,
    output logic              blend_valid,
    input  logic              blend_stall,
    output rpb_pkg::pix_out_t blend
);
    import rpb_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    pix_in_t  in_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    pix_out_t out_reg;
    pix_out_t alu_out;
    logic     out_load;
    logic     in_load;

    // The result register loads when it is empty or its beat leaves now.
    assign out_load = !out_valid_reg || !blend_stall;
    // The input register loads when it is empty or its beat moves on.
    assign in_load  = !in_valid_reg || out_load;
    assign pixel_stall = !in_load;

    assign in_valid_next  = in_load ? pixel_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    rpb_alu u_alu (
        .op_in  (in_reg),
        .op_out (alu_out)
    );

    // Valid flags for both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_load) begin
            in_reg <= pixel;
        end
        if (out_load && in_valid_reg) begin
            out_reg <= alu_out;
        end
    end

    assign blend_valid = out_valid_reg;
    assign blend       = out_reg;

    // A stall toward the source only happens with a beat in both the input and the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (in_valid_reg && out_valid_reg))
        else $error("pixel_stall raised with a free stage");

    // An accepted beat always lands in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> in_valid_reg)
        else $error("accepted beat lost");

    // A beat that moves on always appears as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_load) |=> blend_valid)
        else $error("beat dropped between stages");

    // Unused opcodes give an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_load && in_reg.opcode != OP_SCALE
         && in_reg.opcode != OP_MUL && in_reg.opcode != OP_ADD
         && in_reg.opcode != OP_INV && in_reg.opcode != OP_BLEND)
        |=> (blend.result_color == 16'd0))
        else $error("unused opcode gave a nonzero pixel");

endmodule
